@@ design/tcw_pkg.sv @@
// ----------------------------------------------------------------------------
// Text console cell writer package
// Geometry, derived widths, action and character codes shared by the design.
// ----------------------------------------------------------------------------
`default_nettype none

package tcw_pkg;

	// Screen geometry
	localparam int COLS      = 80;
	localparam int ROWS      = 50;
	localparam int TAB_WIDTH = 8;

	localparam int CELL_COUNT  = COLS * ROWS;
	localparam int SCROLL_LAST = (ROWS - 1) * COLS - 1;
	localparam int LAST_PHASE  = (COLS - 1) % TAB_WIDTH;

	// Derived widths
	localparam int ADDR_W    = $clog2(CELL_COUNT);
	localparam int COL_W     = $clog2(COLS);
	localparam int ROW_W     = $clog2(ROWS);
	localparam int PHASE_W   = $clog2(TAB_WIDTH);
	localparam int TAB_SUM_W = $clog2(COLS + TAB_WIDTH);

	// Fixed field widths of the channels
	localparam int ACTION_W = 2;
	localparam int CHAR_W   = 8;
	localparam int INDEX_W  = 12;
	localparam int CCOL_W   = 7;
	localparam int CROW_W   = 6;
	localparam int CLIN_W   = 12;
	localparam int CELL_W   = 16;
	localparam int ATTR_W   = 8;

	// Action codes
	localparam logic [ACTION_W-1:0] ACT_PUT   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_CLEAR = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_READ  = 2'd2;

	// Character codes
	localparam logic [CHAR_W-1:0] CH_BS    = 8'h08;
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;

	localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h20;
	localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

endpackage

`default_nettype wire

@@ design/tcw_if.sv @@
// ----------------------------------------------------------------------------
// Text console cell writer channels
// Command channel (action, character, cell index) and response channel
// (cursor position and read data), each with a valid/ready transfer.
// ----------------------------------------------------------------------------
`default_nettype none

interface tcw_cmd_if;
	import tcw_pkg::*;

	logic                valid;
	logic                ready;
	logic [ACTION_W-1:0] action;
	logic [CHAR_W-1:0]   char_code;
	logic [INDEX_W-1:0]  cell_index;

	modport source (output valid, output action, output char_code, output cell_index,
		input ready);
	modport sink (input valid, input action, input char_code, input cell_index,
		output ready);
endinterface

interface tcw_rsp_if;
	import tcw_pkg::*;

	logic              valid;
	logic              ready;
	logic [CCOL_W-1:0] cursor_col;
	logic [CROW_W-1:0] cursor_row;
	logic [CLIN_W-1:0] cursor_linear;
	logic [CELL_W-1:0] read_data;

	modport source (output valid, output cursor_col, output cursor_row,
		output cursor_linear, output read_data, input ready);
	modport sink (input valid, input cursor_col, input cursor_row,
		input cursor_linear, input read_data, output ready);
endinterface

`default_nettype wire

@@ design/text_console_cell_writer.sv @@
// ----------------------------------------------------------------------------
// Text console cell writer
// Cursor-driven writer into a COLS x ROWS store of 16-bit character cells.
// ----------------------------------------------------------------------------
// Each command transfer is taken only while the engine is idle. A put that
// does not scroll, an unused action or a read beyond the store passes from
// ST_EXEC to ST_DONE; a read within the store goes through ST_RD_WAIT as
// well, for the registered RAM data. The engine is ready again as soon as
// the response is loaded into the output register, even if the sink has not
// yet taken it. Work that walks the store runs on one address counter and
// the RAM's one write port and one read port: a clear writes all CELL_COUNT
// cells (4000), and a scroll (line feed or wrap on the last row) reads and
// writes back each moved cell, then blanks the last row. After reset the
// store is swept to blanks with attribute 0x20 while no command is taken;
// attribute writes are taken at any time.
// The attribute register is to be written only while the engine is idle.
// ----------------------------------------------------------------------------
`default_nettype none

module text_console_cell_writer (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	tcw_cmd_if.sink                    cmd,
	tcw_rsp_if.source                  rsp,
	input  wire logic                  attr_we,
	input  wire logic [tcw_pkg::ATTR_W-1:0] attr_wdata
);
	import tcw_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_EXEC,
		ST_RD_WAIT,
		ST_SCR_RD,
		ST_SCR_WR,
		ST_FILL,
		ST_DONE
	} state_t;

	state_t state_q;

	// Cursor and tab phase (column modulo TAB_WIDTH, kept alongside the column)
	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic [PHASE_W-1:0] phase_q;

	// Sweep counter for clear, scroll and the reset pass
	logic [ADDR_W-1:0] cnt_q;
	logic [CELL_W-1:0] fill_q;
	logic              reply_q;

	// Captured command
	logic [ACTION_W-1:0] act_q;
	logic [CHAR_W-1:0]   chr_q;
	logic [INDEX_W-1:0]  idx_q;
	logic [CELL_W-1:0]   data_q;

	logic [ATTR_W-1:0] attr_q;

	// Response register
	logic              rsp_valid_q;
	logic [CCOL_W-1:0] rsp_col_q;
	logic [CROW_W-1:0] rsp_row_q;
	logic [CLIN_W-1:0] rsp_lin_q;
	logic [CELL_W-1:0] rsp_data_q;

	// RAM port
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [CELL_W-1:0] ram_wdata;
	logic              ram_re;
	logic [ADDR_W-1:0] ram_raddr;
	logic [CELL_W-1:0] ram_rdata;

	// Cursor arithmetic
	logic [ADDR_W-1:0]    row_base;
	logic [ADDR_W-1:0]    cur_addr;
	logic [ADDR_W-1:0]    bs_addr;
	logic [COL_W-1:0]     col_dec;
	logic [COL_W:0]       col_inc;
	logic [TAB_SUM_W-1:0] tab_sum;
	logic                 is_print;
	logic                 idx_ok;
	logic                 last_row;
	logic [CELL_W-1:0]    blank_cell;

	// One multiply gives the row base for both the write address and the
	// hardware cursor.
	assign row_base   = ADDR_W'(row_q) * ADDR_W'(COLS);
	assign cur_addr   = row_base + ADDR_W'(col_q);
	assign col_dec    = col_q - COL_W'(1);
	assign bs_addr    = row_base + ADDR_W'(col_dec);
	assign col_inc    = {1'b0, col_q} + (COL_W + 1)'(1);
	assign tab_sum    = TAB_SUM_W'(col_q) + TAB_SUM_W'(TAB_WIDTH) - TAB_SUM_W'(phase_q);
	assign is_print   = (chr_q >= CH_SPACE);
	assign idx_ok     = (int'(idx_q) < CELL_COUNT);
	assign last_row   = (row_q == ROW_W'(ROWS - 1));
	assign blank_cell = {attr_q, CH_SPACE};

	assign cmd.ready         = (state_q == ST_IDLE);
	assign rsp.valid         = rsp_valid_q;
	assign rsp.cursor_col    = rsp_col_q;
	assign rsp.cursor_row    = rsp_row_q;
	assign rsp.cursor_linear = rsp_lin_q;
	assign rsp.read_data     = rsp_data_q;

	// Drive the RAM from the sequencer state
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = cnt_q;
		ram_wdata = fill_q;
		ram_re    = 1'b0;
		ram_raddr = cnt_q + ADDR_W'(COLS);
		unique case (state_q)
			ST_EXEC: begin
				if (act_q == ACT_PUT) begin
					if (chr_q == CH_BS && col_q != '0) begin
						ram_we    = 1'b1;
						ram_waddr = bs_addr;
						ram_wdata = blank_cell;
					end else if (is_print) begin
						ram_we    = 1'b1;
						ram_waddr = cur_addr;
						ram_wdata = {attr_q, chr_q};
					end
				end else if (act_q == ACT_READ && idx_ok) begin
					ram_re    = 1'b1;
					ram_raddr = ADDR_W'(idx_q);
				end
			end
			ST_SCR_RD: begin
				// fetch the cell one row below the destination
				ram_re = 1'b1;
			end
			ST_SCR_WR: begin
				ram_we    = 1'b1;
				ram_wdata = ram_rdata;
			end
			ST_FILL: begin
				ram_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	tcw_ram #(
		.WIDTH (CELL_W),
		.DEPTH (CELL_COUNT)
	) u_cells (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (ram_re),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Attribute register: written whenever the enable is high
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			attr_q <= RESET_ATTR;
		end else if (attr_we) begin
			attr_q <= attr_wdata;
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_FILL;
			col_q       <= '0;
			row_q       <= '0;
			phase_q     <= '0;
			cnt_q       <= '0;
			fill_q      <= RESET_BLANK;
			reply_q     <= 1'b0;
			act_q       <= '0;
			chr_q       <= '0;
			idx_q       <= '0;
			data_q      <= '0;
			rsp_valid_q <= 1'b0;
			rsp_col_q   <= '0;
			rsp_row_q   <= '0;
			rsp_lin_q   <= '0;
			rsp_data_q  <= '0;
		end else begin
			// drop the response once the sink has taken it, unless a new one
			// is loaded in its place
			if (rsp_valid_q && rsp.ready && state_q != ST_DONE) begin
				rsp_valid_q <= 1'b0;
			end

			unique case (state_q)
				ST_IDLE: begin
					if (cmd.valid) begin
						act_q   <= cmd.action;
						chr_q   <= cmd.char_code;
						idx_q   <= cmd.cell_index;
						state_q <= ST_EXEC;
					end
				end

				ST_EXEC: begin
					data_q <= '0;
					case (act_q)
						ACT_PUT: begin
							if (chr_q == CH_BS) begin
								if (col_q != '0) begin
									col_q   <= col_dec;
									phase_q <= (phase_q == '0) ?
										PHASE_W'(TAB_WIDTH - 1) : phase_q - PHASE_W'(1);
								end
								state_q <= ST_DONE;
							end else if (chr_q == CH_TAB) begin
								// clamp to the last column past the right edge
								if (tab_sum > TAB_SUM_W'(COLS - 1)) begin
									col_q   <= COL_W'(COLS - 1);
									phase_q <= PHASE_W'(LAST_PHASE);
								end else begin
									col_q   <= COL_W'(tab_sum);
									phase_q <= '0;
								end
								state_q <= ST_DONE;
							end else if (chr_q == CH_CR) begin
								col_q   <= '0;
								phase_q <= '0;
								state_q <= ST_DONE;
							end else if (chr_q == CH_LF ||
								(is_print && col_inc == (COL_W + 1)'(COLS))) begin
								// new line, scrolling on the last row
								col_q   <= '0;
								phase_q <= '0;
								if (last_row) begin
									cnt_q   <= '0;
									state_q <= ST_SCR_RD;
								end else begin
									row_q   <= row_q + ROW_W'(1);
									state_q <= ST_DONE;
								end
							end else if (is_print) begin
								col_q   <= COL_W'(col_inc);
								phase_q <= (phase_q == PHASE_W'(TAB_WIDTH - 1)) ?
									'0 : phase_q + PHASE_W'(1);
								state_q <= ST_DONE;
							end else begin
								// other control bytes leave the cursor alone
								state_q <= ST_DONE;
							end
						end
						ACT_CLEAR: begin
							col_q   <= '0;
							row_q   <= '0;
							phase_q <= '0;
							cnt_q   <= '0;
							fill_q  <= blank_cell;
							reply_q <= 1'b1;
							state_q <= ST_FILL;
						end
						ACT_READ: begin
							state_q <= idx_ok ? ST_RD_WAIT : ST_DONE;
						end
						default: begin
							state_q <= ST_DONE;
						end
					endcase
				end

				ST_RD_WAIT: begin
					data_q  <= ram_rdata;
					state_q <= ST_DONE;
				end

				ST_SCR_RD: begin
					state_q <= ST_SCR_WR;
				end

				ST_SCR_WR: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == ADDR_W'(SCROLL_LAST)) begin
						// moved every row up: blank the last row
						fill_q  <= blank_cell;
						reply_q <= 1'b1;
						state_q <= ST_FILL;
					end else begin
						state_q <= ST_SCR_RD;
					end
				end

				ST_FILL: begin
					cnt_q <= cnt_q + ADDR_W'(1);
					if (cnt_q == ADDR_W'(CELL_COUNT - 1)) begin
						state_q <= reply_q ? ST_DONE : ST_IDLE;
					end
				end

				ST_DONE: begin
					// hold until the output register is free
					if (!rsp_valid_q || rsp.ready) begin
						rsp_valid_q <= 1'b1;
						rsp_col_q   <= CCOL_W'(col_q);
						rsp_row_q   <= CROW_W'(row_q);
						rsp_lin_q   <= CLIN_W'(cur_addr);
						rsp_data_q  <= data_q;
						state_q     <= ST_IDLE;
					end
				end

				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The cursor never leaves the screen
	a_cursor_on_screen: assert property (@(posedge clk) disable iff (!arst_n)
		(col_q <= COL_W'(COLS - 1)) && (row_q <= ROW_W'(ROWS - 1)))
		else $error("cursor outside the screen");

	// An accepted command holds off the next one in the following cycle
	a_busy_after_transfer: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.valid && cmd.ready) |=> !cmd.ready)
		else $error("command taken while the previous one is in progress");

	// The store is written only while a command or a sweep is in progress
	a_no_write_when_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.ready |-> !ram_we)
		else $error("cell store written while idle");

endmodule

`default_nettype wire

@@ design/tcw_ram.sv @@
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module tcw_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4000
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire
